/* hdl/sfe_pkg.sv */
// Shared constants, request types and state encodings of the string folding encoder.
`default_nettype none

package sfe_pkg;

  localparam int MAX_LEN_DEF = 64;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } sym_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       truncated;
  } txt_req_t;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_DP,
    PH_EMIT
  } phase_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_DIAG,
    DP_SPL_RD,
    DP_SPL_CMP,
    DP_PER_RD,
    DP_PER_CMP,
    DP_PER_COST,
    DP_PER_VAL,
    DP_WR
  } dp_state_t;

  typedef enum logic [3:0] {
    EM_IDLE,
    EM_POP,
    EM_TOP,
    EM_SYM,
    EM_TAB,
    EM_PUSH_HI,
    EM_PUSH_LO,
    EM_DIV,
    EM_TENS,
    EM_ONES,
    EM_OPEN,
    EM_PUSH_MARK,
    EM_PUSH_BODY,
    EM_PUT,
    EM_FLUSH
  } em_state_t;

endpackage

`default_nettype wire

/* hdl/string_folding_encoder_top.sv */
// Top level of the string folding encoder: symbol loading, memories and phase control.
// Symbols are taken one per cycle while in the load phase; after the last one the table pass
// fills the single spans, then for each longer span scans the split points, compares pairs for
// each period and writes the span's entry back to the table RAM.
// Emission sends ')' and symbols, and for repetition nodes a one- or two-digit count and '(',
// and waits on output stalls; reset clears control state only.
`default_nettype none

module string_folding_encoder_top import sfe_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     sym_valid,
  output logic     sym_stall,
  input  sym_req_t sym_data,
  output logic     txt_valid,
  input  logic     txt_stall,
  output txt_req_t txt_data
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int ENT_W = CNT_W + 1 + IDX_W;
  localparam int TAB_AW = 2 * IDX_W;

  phase_t phase, phase_next;

  logic [CNT_W-1:0]  len, n;
  logic              ovf, dp_start, em_start, dp_done, em_done, sym_take, sym_we;
  logic [IDX_W-1:0]  sym_ra, sym_rb, dp_sa, dp_sb, em_sa;
  logic [7:0]        sym_qa, sym_qb;
  logic [TAB_AW-1:0] tab_ra, tab_rb, dp_ta, em_ta, tab_waddr;
  logic [ENT_W-1:0]  tab_qa, tab_qb, tab_wdata;
  logic              tab_we;

  sfe_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_sym (
    .clk     (clk),
    .we      (sym_we),
    .waddr   (len[IDX_W-1:0]),
    .wdata   (sym_data.symbol),
    .raddr_a (sym_ra),
    .rdata_a (sym_qa),
    .raddr_b (sym_rb),
    .rdata_b (sym_qb)
  );

  sfe_ram #(.WIDTH(ENT_W), .DEPTH(1 << TAB_AW)) u_tab (
    .clk     (clk),
    .we      (tab_we),
    .waddr   (tab_waddr),
    .wdata   (tab_wdata),
    .raddr_a (tab_ra),
    .rdata_a (tab_qa),
    .raddr_b (tab_rb),
    .rdata_b (tab_qb)
  );

  sfe_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .start      (dp_start),
    .n          (n),
    .done       (dp_done),
    .sym_addr_a (dp_sa),
    .sym_addr_b (dp_sb),
    .sym_data_a (sym_qa),
    .sym_data_b (sym_qb),
    .tab_addr_a (dp_ta),
    .tab_addr_b (tab_rb),
    .tab_data_a (tab_qa),
    .tab_data_b (tab_qb),
    .tab_we     (tab_we),
    .tab_waddr  (tab_waddr),
    .tab_wdata  (tab_wdata)
  );

  sfe_emit #(.MAX_LEN(MAX_LEN)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (em_start),
    .n         (n),
    .trunc     (ovf),
    .done      (em_done),
    .sym_addr  (em_sa),
    .sym_data  (sym_qa),
    .tab_addr  (em_ta),
    .tab_data  (tab_qa),
    .txt_valid (txt_valid),
    .txt_stall (txt_stall),
    .txt_data  (txt_data)
  );

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_LOAD: if (sym_take && sym_data.last) phase_next = PH_DP;
      PH_DP:   if (dp_done) phase_next = PH_EMIT;
      PH_EMIT: if (em_done) phase_next = PH_LOAD;
      default: phase_next = PH_LOAD;
    endcase
  end

  always_comb begin
    sym_stall = (phase != PH_LOAD);
    sym_take  = sym_valid && !sym_stall;
    sym_we    = sym_take && (len < CNT_W'(MAX_LEN));
    n         = (len == '0) ? CNT_W'(1) : len;
    sym_ra    = (phase == PH_EMIT) ? em_sa : dp_sa;
    sym_rb    = dp_sb;
    tab_ra    = (phase == PH_EMIT) ? em_ta : dp_ta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LOAD;
      len      <= '0;
      ovf      <= 1'b0;
      dp_start <= 1'b0;
      em_start <= 1'b0;
    end else begin
      phase    <= phase_next;
      dp_start <= sym_take && sym_data.last;
      em_start <= dp_done;
      if (sym_take) begin
        if (len < CNT_W'(MAX_LEN)) begin
          len <= len + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (em_done) begin
        len <= '0;
        ovf <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/sfe_ram.sv */
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none

module sfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* hdl/sfe_dp.sv */
// Interval dynamic program that fills the cost and choice table span by span.
`default_nettype none

module sfe_dp import sfe_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  localparam int IDX_W = $clog2(MAX_LEN),
  localparam int CNT_W = $clog2(MAX_LEN + 1),
  localparam int ENT_W = CNT_W + 1 + IDX_W,
  localparam int TAB_AW = 2 * IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  n,
  output logic              done,
  output logic [IDX_W-1:0]  sym_addr_a,
  output logic [IDX_W-1:0]  sym_addr_b,
  input  logic [7:0]        sym_data_a,
  input  logic [7:0]        sym_data_b,
  output logic [TAB_AW-1:0] tab_addr_a,
  output logic [TAB_AW-1:0] tab_addr_b,
  input  logic [ENT_W-1:0]  tab_data_a,
  input  logic [ENT_W-1:0]  tab_data_b,
  output logic              tab_we,
  output logic [TAB_AW-1:0] tab_waddr,
  output logic [ENT_W-1:0]  tab_wdata
);

  localparam int SUM_W = CNT_W + 1;
  localparam int TWO_DIGIT_Q = 9;

  dp_state_t state, state_next;

  logic [IDX_W-1:0] le, l, m, k, pa, pb, pos, q, arg;
  logic [SUM_W-1:0] best;
  logic             kind;

  logic [CNT_W-1:0] n_dec;
  logic [IDX_W-1:0] last_idx, r, m_inc, k_inc, pos_inc, pos_next, q_next, body_end;
  logic [SUM_W-1:0] split_sum, rep_sum;
  logic             last_m, last_k, seg_end, mismatch, per_fail;

  assign n_dec     = n - 1'b1;
  assign last_idx  = n_dec[IDX_W-1:0];
  assign r         = l + le;
  assign m_inc     = m + 1'b1;
  assign k_inc     = k + 1'b1;
  assign pos_inc   = pos + 1'b1;
  assign pos_next  = (pos_inc == k) ? '0 : pos_inc;
  assign q_next    = (pos_inc == k) ? q + 1'b1 : q;
  assign body_end  = l + k - 1'b1;
  assign last_m    = (m_inc == r);
  assign last_k    = (k == le);
  assign seg_end   = (pb == r);
  assign mismatch  = (sym_data_a != sym_data_b);
  assign per_fail  = mismatch || (seg_end && (pos_next != '0));
  assign split_sum = SUM_W'(tab_data_a[ENT_W-1 -: CNT_W])
                   + SUM_W'(tab_data_b[ENT_W-1 -: CNT_W]);
  assign rep_sum   = SUM_W'(tab_data_a[ENT_W-1 -: CNT_W])
                   + ((int'(q) >= TWO_DIGIT_Q) ? SUM_W'(4) : SUM_W'(3));

  always_comb begin
    state_next = state;
    unique case (state)
      DP_IDLE: begin
        if (start) state_next = DP_DIAG;
      end
      DP_DIAG: begin
        if (l == last_idx) state_next = (last_idx == '0) ? DP_IDLE : DP_SPL_RD;
      end
      DP_SPL_RD:   state_next = DP_SPL_CMP;
      DP_SPL_CMP:  state_next = last_m ? DP_PER_RD : DP_SPL_RD;
      DP_PER_RD:   state_next = DP_PER_CMP;
      DP_PER_CMP: begin
        if (per_fail) state_next = last_k ? DP_WR : DP_PER_RD;
        else if (seg_end) state_next = DP_PER_COST;
        else state_next = DP_PER_RD;
      end
      DP_PER_COST: state_next = DP_PER_VAL;
      DP_PER_VAL:  state_next = last_k ? DP_WR : DP_PER_RD;
      DP_WR: begin
        state_next = (r == last_idx && le == last_idx) ? DP_IDLE : DP_SPL_RD;
      end
      default:     state_next = DP_IDLE;
    endcase
  end

  always_comb begin
    done       = (state == DP_WR && r == last_idx && le == last_idx)
              || (state == DP_DIAG && l == last_idx && last_idx == '0);
    sym_addr_a = pa;
    sym_addr_b = pb;
    tab_addr_a = (state == DP_PER_COST) ? {l, body_end} : {l, m};
    tab_addr_b = {m_inc, r};
    tab_we     = (state == DP_DIAG) || (state == DP_WR);
    tab_waddr  = (state == DP_DIAG) ? {l, l} : {l, r};
    tab_wdata  = (state == DP_DIAG) ? {CNT_W'(1), 1'b0, {IDX_W{1'b0}}}
                                    : {best[CNT_W-1:0], kind, arg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DP_IDLE: begin
        if (start) l <= '0;
      end
      DP_DIAG: begin
        if (l == last_idx) begin
          l  <= '0;
          le <= IDX_W'(1);
          m  <= '0;
        end else begin
          l <= l + 1'b1;
        end
      end
      DP_SPL_CMP: begin
        if (m == l || split_sum < best) begin
          best <= split_sum;
          arg  <= m;
        end
        kind <= 1'b0;
        if (last_m) begin
          k   <= IDX_W'(1);
          pa  <= l;
          pb  <= l + 1'b1;
          pos <= '0;
          q   <= '0;
        end else begin
          m <= m_inc;
        end
      end
      DP_PER_CMP: begin
        if (per_fail) begin
          k   <= k_inc;
          pa  <= l;
          pb  <= l + k_inc;
          pos <= '0;
          q   <= '0;
        end else begin
          if (!seg_end) begin
            pa <= pa + 1'b1;
            pb <= pb + 1'b1;
          end
          pos <= pos_next;
          q   <= q_next;
        end
      end
      DP_PER_VAL: begin
        if (rep_sum < best) begin
          best <= rep_sum;
          kind <= 1'b1;
          arg  <= k;
        end
        k   <= k_inc;
        pa  <= l;
        pb  <= l + k_inc;
        pos <= '0;
        q   <= '0;
      end
      DP_WR: begin
        if (r == last_idx) begin
          le <= le + 1'b1;
          l  <= '0;
          m  <= '0;
        end else begin
          l <= l + 1'b1;
          m <= l + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/sfe_emit.sv */
// Walks the choice table with an explicit span stack and sends the folded text byte by byte.
`default_nettype none

module sfe_emit import sfe_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  localparam int IDX_W = $clog2(MAX_LEN),
  localparam int CNT_W = $clog2(MAX_LEN + 1),
  localparam int ENT_W = CNT_W + 1 + IDX_W,
  localparam int TAB_AW = 2 * IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  n,
  input  logic              trunc,
  output logic              done,
  output logic [IDX_W-1:0]  sym_addr,
  input  logic [7:0]        sym_data,
  output logic [TAB_AW-1:0] tab_addr,
  input  logic [ENT_W-1:0]  tab_data,
  output logic              txt_valid,
  input  logic              txt_stall,
  output txt_req_t          txt_data
);

  localparam int SE_W = 1 + 2 * IDX_W;
  localparam logic [IDX_W-1:0] ZERO_IDX = '0;

  em_state_t state, state_next, ret;

  logic [CNT_W-1:0] sp, cnt, rem;
  logic [IDX_W-1:0] el, er, em_arg;
  logic [3:0]       ones, tens;
  logic [7:0]       ch, pend;
  logic             pend_valid;

  logic             st_we;
  logic [IDX_W-1:0] st_waddr, st_raddr;
  logic [SE_W-1:0]  st_wdata, st_rdata, st_peek;
  logic [CNT_W-1:0] sp_dec, n_dec;
  logic             e_mark, leaf, push_en, room, full_cnt, out_free, put_take, out_load;
  logic [IDX_W-1:0] e_l, e_r, period, body_end, arg_inc;

  sfe_ram #(.WIDTH(SE_W), .DEPTH(MAX_LEN)) u_stack (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (st_raddr),
    .rdata_a (st_rdata),
    .raddr_b (st_raddr),
    .rdata_b (st_peek)
  );

  assign sp_dec   = sp - 1'b1;
  assign n_dec    = n - 1'b1;
  assign st_raddr = sp_dec[IDX_W-1:0];
  assign e_mark   = st_peek[SE_W-1];
  assign e_l      = st_rdata[2*IDX_W-1 -: IDX_W];
  assign e_r      = st_rdata[IDX_W-1:0];
  assign leaf     = (e_l >= e_r) || (CNT_W'(e_r) >= n);
  assign period   = (em_arg == '0) ? IDX_W'(1) : em_arg;
  assign body_end = el + period - 1'b1;
  assign arg_inc  = em_arg + 1'b1;
  assign room     = (sp < CNT_W'(MAX_LEN));
  assign full_cnt = (cnt == CNT_W'(MAX_LEN));
  assign out_free = !txt_valid || !txt_stall;
  assign put_take = (state == EM_PUT) && !full_cnt && (!pend_valid || out_free);
  assign push_en  = (state == EM_PUSH_HI) || (state == EM_PUSH_LO)
                 || (state == EM_PUSH_MARK) || (state == EM_PUSH_BODY);

  always_comb begin
    state_next = state;
    unique case (state)
      EM_IDLE:  if (start) state_next = EM_POP;
      EM_POP:   state_next = (sp == '0 || full_cnt) ? EM_FLUSH : EM_TOP;
      EM_TOP: begin
        if (e_mark) state_next = EM_PUT;
        else if (leaf) state_next = EM_SYM;
        else state_next = EM_TAB;
      end
      EM_SYM:   state_next = EM_PUT;
      EM_TAB: begin
        if (!tab_data[IDX_W]) state_next = EM_PUSH_HI;
        else if (tab_data[IDX_W-1:0] == '0) state_next = EM_TENS;
        else state_next = EM_DIV;
      end
      EM_PUSH_HI:   state_next = EM_PUSH_LO;
      EM_PUSH_LO:   state_next = EM_POP;
      EM_DIV:       if (rem < CNT_W'(em_arg)) state_next = EM_TENS;
      EM_TENS:      state_next = (tens != '0) ? EM_PUT : EM_ONES;
      EM_ONES:      state_next = EM_PUT;
      EM_OPEN:      state_next = EM_PUT;
      EM_PUSH_MARK: state_next = EM_PUSH_BODY;
      EM_PUSH_BODY: state_next = EM_POP;
      EM_PUT:       if (full_cnt || !pend_valid || out_free) state_next = ret;
      EM_FLUSH:     if (!pend_valid || out_free) state_next = EM_IDLE;
      default:      state_next = EM_IDLE;
    endcase
  end

  always_comb begin
    done     = (state == EM_FLUSH) && (!pend_valid || out_free);
    out_load = ((state == EM_PUT) && !full_cnt && pend_valid && out_free)
            || ((state == EM_FLUSH) && pend_valid && out_free);
    sym_addr = (CNT_W'(e_l) < n) ? e_l : '0;
    tab_addr = {e_l, e_r};
    st_we    = ((state == EM_IDLE) && start) || (push_en && room);
    st_waddr = (state == EM_IDLE) ? '0 : sp[IDX_W-1:0];
    unique case (state)
      EM_IDLE:      st_wdata = {1'b0, ZERO_IDX, n_dec[IDX_W-1:0]};
      EM_PUSH_HI:   st_wdata = {1'b0, arg_inc, er};
      EM_PUSH_LO:   st_wdata = {1'b0, el, em_arg};
      EM_PUSH_MARK: st_wdata = {1'b1, ZERO_IDX, ZERO_IDX};
      EM_PUSH_BODY: st_wdata = {1'b0, el, body_end};
      default:      st_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= EM_IDLE;
      sp         <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      txt_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        txt_valid <= 1'b1;
      end else if (!txt_stall) begin
        txt_valid <= 1'b0;
      end
      if (state == EM_IDLE && start) begin
        sp         <= CNT_W'(1);
        cnt        <= '0;
        pend_valid <= 1'b0;
      end else if (state == EM_POP && sp != '0 && !full_cnt) begin
        sp <= sp_dec;
      end else if (push_en && room) begin
        sp <= sp + 1'b1;
      end
      if (put_take) begin
        cnt        <= cnt + 1'b1;
        pend_valid <= 1'b1;
      end
      if (done) begin
        sp         <= '0;
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      txt_data.out_char  <= pend;
      txt_data.out_last  <= (state == EM_FLUSH);
      txt_data.truncated <= trunc;
    end
    if (put_take) begin
      pend <= ch;
    end
    unique case (state)
      EM_TOP: begin
        el  <= e_l;
        er  <= e_r;
        ch  <= CH_CLOSE;
        ret <= EM_POP;
      end
      EM_SYM: begin
        ch  <= sym_data;
        ret <= EM_POP;
      end
      EM_TAB: begin
        em_arg <= tab_data[IDX_W-1:0];
        rem    <= CNT_W'(er) - CNT_W'(el) + 1'b1;
        tens   <= '0;
        ones   <= (tab_data[IDX_W-1:0] == '0) ? 4'd1 : 4'd0;
      end
      EM_DIV: begin
        if (rem >= CNT_W'(em_arg)) begin
          rem <= rem - CNT_W'(em_arg);
          if (ones == 4'd9) begin
            ones <= '0;
            tens <= tens + 1'b1;
          end else begin
            ones <= ones + 1'b1;
          end
        end
      end
      EM_TENS: begin
        ch  <= CH_ZERO + {4'b0000, tens};
        ret <= EM_ONES;
      end
      EM_ONES: begin
        ch  <= CH_ZERO + {4'b0000, ones};
        ret <= EM_OPEN;
      end
      EM_OPEN: begin
        ch  <= CH_OPEN;
        ret <= EM_PUSH_MARK;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
